@@ src/lh_pkg.sv @@
// Package for the latency histogram block.
// Payload structs, field widths, codes and reset constants.
// No dependencies.
`default_nettype none

package lh_pkg;

  localparam int MAX_BUCKETS_DEF = 1024;
  localparam int SAMPLE_BITS     = 31;
  localparam int COUNT_BITS      = 11;
  localparam int WIDTH_BITS      = 31;
  localparam int INDEX_BITS      = 10;
  localparam int VALUE_BITS      = 32;
  localparam int SUM_BITS        = 64;
  localparam int CFG_INDEX_BITS  = 2;
  localparam int DIV_CNT_BITS    = $clog2(SAMPLE_BITS);

  localparam logic [SAMPLE_BITS-1:0] MIN_RESET = SAMPLE_BITS'(999999999);

  typedef enum logic [1:0] {
    MODE_RECORD = 2'd0,
    MODE_READ   = 2'd1,
    MODE_CLEAR  = 2'd2
  } lh_mode_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_BUCKET_COUNT = 2'd0,
    CFG_BUCKET_WIDTH = 2'd1
  } lh_cfg_t;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_DIV,
    ST_CHK,
    ST_FIN
  } lh_state_t;

  typedef struct packed {
    logic [1:0]             mode;
    logic [SAMPLE_BITS-1:0] sample;
    logic [INDEX_BITS-1:0]  read_index;
  } lh_req_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0]  bucket_index;
    logic [VALUE_BITS-1:0]  bucket_value;
    logic                   was_overflow;
    logic [SAMPLE_BITS-1:0] min_seen;
    logic [SAMPLE_BITS-1:0] max_seen;
    logic [VALUE_BITS-1:0]  overflow_total;
    logic [VALUE_BITS-1:0]  sample_total;
    logic [SUM_BITS-1:0]    sum_total;
  } lh_rsp_t;

endpackage

`default_nettype wire

@@ src/latency_histogram.sv @@
// Latency histogram with a bit-serial restoring divider and a bucket RAM; uses lh_pkg.
// Record: accept, divide, check, write-back, then back to idle for the next request.
// Read: check, then write-back. Unused mode: straight to write-back. Write-back waits on rsp_stall.
// Clear: the one-entry-per-cycle RAM sweep, then write-back.
// Reset (rst, synchronous) clears statistics, then sweeps the RAM with req_stall high;
// configuration writes are taken throughout.
`default_nettype none

module latency_histogram
  import lh_pkg::*;
#(
  parameter int MAX_BUCKETS = MAX_BUCKETS_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      req_valid,
  output logic                           req_stall,
  input  wire lh_req_t                   req,
  output logic                           rsp_valid,
  input  wire logic                      rsp_stall,
  output lh_rsp_t                        rsp,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [WIDTH_BITS-1:0]     cfg_data
);

  localparam int AW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int SB = SAMPLE_BITS;

  lh_state_t state, state_next;

  logic [COUNT_BITS-1:0]   bucket_count;
  logic [WIDTH_BITS-1:0]   bucket_width;

  logic [1:0]              op;
  logic [SB-1:0]           sample_q;
  logic [SB-1:0]           quo;
  logic [SB-1:0]           rem;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic [INDEX_BITS-1:0]   ridx;
  logic                    hit;
  logic                    ovf_q;
  logic                    clr_pending;
  logic [AW-1:0]           sweep_ptr;

  logic [SB-1:0]           min_reg;
  logic [SB-1:0]           max_reg;
  logic [VALUE_BITS-1:0]   overflow_reg;
  logic [VALUE_BITS-1:0]   count_reg;
  logic [SUM_BITS-1:0]     sum_reg;

  logic [VALUE_BITS-1:0]   mem [MAX_BUCKETS];
  logic [VALUE_BITS-1:0]   mem_q;

  // combinational
  logic                    accept;
  logic                    slot_free;
  logic                    commit;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  logic [VALUE_BITS-1:0]   mem_wdata;
  logic [COUNT_BITS-1:0]   active;
  logic                    rec_fits;
  logic                    rd_in_range;
  logic                    chk_hit;
  logic                    sweep_done;
  logic [SB:0]             rem_sh;
  logic [SB+1:0]           diff;
  logic                    qbit;
  logic [SB-1:0]           rem_step;
  logic [VALUE_BITS-1:0]   bump;
  logic [SB-1:0]           min_next;
  logic [SB-1:0]           max_next;
  logic [VALUE_BITS-1:0]   overflow_next;
  logic [VALUE_BITS-1:0]   count_next;
  logic [SUM_BITS-1:0]     sum_next;
  lh_rsp_t                 rsp_next;

  assign cfg_ready = 1'b1;

  // bucket_count above the RAM depth acts as the depth
  always_comb begin
    if (MAX_BUCKETS < 2**COUNT_BITS && bucket_count > COUNT_BITS'(MAX_BUCKETS)) begin
      active = COUNT_BITS'(MAX_BUCKETS);
    end else begin
      active = bucket_count;
    end
  end

  assign rec_fits    = quo < SB'(active);
  assign rd_in_range = COUNT_BITS'(ridx) < active;
  assign chk_hit     = (op == MODE_RECORD && rec_fits) || (op == MODE_READ && rd_in_range);
  assign sweep_done  = sweep_ptr == AW'(MAX_BUCKETS - 1);

  // restoring divide step; a zero divisor yields an all-ones quotient
  assign rem_sh   = {rem, quo[SB-1]};
  assign diff     = {1'b0, rem_sh} - (SB+2)'(bucket_width);
  assign qbit     = ~diff[SB+1];
  assign rem_step = qbit ? diff[SB-1:0] : rem_sh[SB-1:0];

  assign bump = mem_q + VALUE_BITS'(1);

  // statistics and result after the operation
  always_comb begin
    min_next      = min_reg;
    max_next      = max_reg;
    overflow_next = overflow_reg;
    count_next    = count_reg;
    sum_next      = sum_reg;
    rsp_next      = '0;
    case (op)
      MODE_RECORD: begin
        count_next = count_reg + VALUE_BITS'(1);
        sum_next   = sum_reg + SUM_BITS'(sample_q);
        min_next   = (sample_q < min_reg) ? sample_q : min_reg;
        max_next   = (sample_q > max_reg) ? sample_q : max_reg;
        if (ovf_q) begin
          overflow_next         = overflow_reg + VALUE_BITS'(1);
          rsp_next.was_overflow = 1'b1;
        end else begin
          rsp_next.bucket_index = INDEX_BITS'(quo);
          rsp_next.bucket_value = bump;
        end
      end
      MODE_READ: begin
        rsp_next.bucket_index = ridx;
        rsp_next.bucket_value = hit ? mem_q : '0;
      end
      MODE_CLEAR: begin
        min_next      = MIN_RESET;
        max_next      = '0;
        overflow_next = '0;
        count_next    = '0;
        sum_next      = '0;
      end
      default: begin
      end
    endcase
    rsp_next.min_seen       = min_next;
    rsp_next.max_seen       = max_next;
    rsp_next.overflow_total = overflow_next;
    rsp_next.sample_total   = count_next;
    rsp_next.sum_total      = sum_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    accept     = 1'b0;
    slot_free  = ~rsp_valid | ~rsp_stall;
    commit     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = (op == MODE_RECORD) ? AW'(quo) : AW'(ridx);
    mem_we     = 1'b0;
    mem_waddr  = AW'(quo);
    mem_wdata  = bump;
    unique case (state)
      ST_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_ptr;
        mem_wdata = '0;
        if (sweep_done) begin
          state_next = clr_pending ? ST_FIN : ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_stall = 1'b0;
        accept    = req_valid;
        if (req_valid) begin
          unique case (req.mode)
            MODE_RECORD: state_next = ST_DIV;
            MODE_READ:   state_next = ST_CHK;
            MODE_CLEAR:  state_next = ST_SWEEP;
            default:     state_next = ST_FIN;
          endcase
        end
      end
      ST_DIV: begin
        if (div_cnt == '0) begin
          state_next = ST_CHK;
        end
      end
      ST_CHK: begin
        rd_en      = chk_hit;
        state_next = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          commit     = 1'b1;
          mem_we     = (op == MODE_RECORD) && hit;
          state_next = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= '0;
      bucket_width <= WIDTH_BITS'(1);
      clr_pending  <= 1'b0;
      sweep_ptr    <= '0;
      rsp_valid    <= 1'b0;
      min_reg      <= MIN_RESET;
      max_reg      <= '0;
      overflow_reg <= '0;
      count_reg    <= '0;
      sum_reg      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BUCKET_COUNT: bucket_count <= cfg_data[COUNT_BITS-1:0];
          CFG_BUCKET_WIDTH: bucket_width <= cfg_data;
          default: begin
          end
        endcase
      end

      if (accept) begin
        op          <= req.mode;
        sample_q    <= req.sample;
        quo         <= req.sample;
        rem         <= '0;
        div_cnt     <= DIV_CNT_BITS'(SB - 1);
        ridx        <= req.read_index;
        clr_pending <= req.mode == MODE_CLEAR;
        sweep_ptr   <= '0;
      end

      if (state == ST_DIV) begin
        rem     <= rem_step;
        quo     <= {quo[SB-2:0], qbit};
        div_cnt <= div_cnt - DIV_CNT_BITS'(1);
      end

      if (state == ST_CHK) begin
        hit   <= chk_hit;
        ovf_q <= (op == MODE_RECORD) && !rec_fits;
      end

      if (state == ST_SWEEP) begin
        sweep_ptr <= sweep_ptr + AW'(1);
      end

      if (commit) begin
        min_reg      <= min_next;
        max_reg      <= max_next;
        overflow_reg <= overflow_next;
        count_reg    <= count_next;
        sum_reg      <= sum_next;
        rsp          <= rsp_next;
      end

      rsp_valid <= commit | (rsp_valid & rsp_stall);
    end
  end

  // a result is only loaded from the write-back state
  a_rsp_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == ST_FIN)
    else $error("result appeared outside write-back");

  // statistics move only on write-back
  a_stats_hold: assert property (@(posedge clk) disable iff (rst)
    state != ST_FIN |=> $stable(count_reg) && $stable(sum_reg) && $stable(overflow_reg))
    else $error("statistics changed outside write-back");

  // the divider runs its full count
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && div_cnt != '0 |=> state == ST_DIV)
    else $error("divider left early");

  // no write-back while the previous result is still stalled
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp))
    else $error("stalled result overwritten");

endmodule

`default_nettype wire

@@ bench/tb_latency_histogram.sv @@
`timescale 1ns / 1ps
// Self-checking bench for latency_histogram: random and directed record/read/clear/unused-mode traffic.
// A scoreboard class tracks its own histogram state and checks every response transfer.
// Depends on lh_pkg and the latency_histogram RTL.

module tb_latency_histogram;
  import lh_pkg::*;

  localparam logic [1:0]                MODE_UNUSED  = 2'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED = 2'd3;
  localparam logic [WIDTH_BITS-1:0]     WIDTH_MAX    = {WIDTH_BITS{1'b1}};
  localparam int                        PHASE_ITEMS  = 100;

  class histogram_scoreboard;
    logic [VALUE_BITS-1:0]  hist [MAX_BUCKETS_DEF];
    logic [SAMPLE_BITS-1:0] lo_seen, hi_seen;
    logic [VALUE_BITS-1:0]  ovf_cnt, rec_cnt;
    logic [SUM_BITS-1:0]    lat_sum;
    logic [COUNT_BITS-1:0]  n_buckets;
    logic [WIDTH_BITS-1:0]  bin_width;
    lh_rsp_t                expected_q[$];
    int                     failures;

    function new();
      n_buckets = '0;
      bin_width = WIDTH_BITS'(1);
      failures  = 0;
      clear_stats();
    endfunction

    function void clear_stats();
      foreach (hist[i]) hist[i] = '0;
      lo_seen = MIN_RESET;
      hi_seen = '0;
      ovf_cnt = '0;
      rec_cnt = '0;
      lat_sum = '0;
    endfunction

    function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [WIDTH_BITS-1:0] data);
      if (idx == CFG_BUCKET_COUNT) n_buckets = data[COUNT_BITS-1:0];
      else if (idx == CFG_BUCKET_WIDTH) bin_width = data;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(lh_req_t r);
      lh_rsp_t               e;
      logic [SUM_BITS-1:0]   bin;
      logic [COUNT_BITS-1:0] active;
      e = '0;
      active = (n_buckets > MAX_BUCKETS_DEF) ? COUNT_BITS'(MAX_BUCKETS_DEF) : n_buckets;
      case (r.mode)
        MODE_RECORD: begin
          rec_cnt = rec_cnt + 1;
          lat_sum = lat_sum + SUM_BITS'(r.sample);
          if (r.sample > hi_seen) hi_seen = r.sample;
          if (r.sample < lo_seen) lo_seen = r.sample;
          // zero divisor behaves as an all-ones quotient
          bin = (bin_width == 0) ? '1 : SUM_BITS'(r.sample) / SUM_BITS'(bin_width);
          if (bin >= SUM_BITS'(active)) begin
            ovf_cnt = ovf_cnt + 1;
            e.was_overflow = 1'b1;
          end else begin
            hist[bin[INDEX_BITS-1:0]] = hist[bin[INDEX_BITS-1:0]] + 1;
            e.bucket_index = bin[INDEX_BITS-1:0];
            e.bucket_value = hist[bin[INDEX_BITS-1:0]];
          end
        end
        MODE_READ: begin
          e.bucket_index = r.read_index;
          if (COUNT_BITS'(r.read_index) < active) e.bucket_value = hist[r.read_index];
        end
        MODE_CLEAR: clear_stats();
        default: ;
      endcase
      e.min_seen       = lo_seen;
      e.max_seen       = hi_seen;
      e.overflow_total = ovf_cnt;
      e.sample_total   = rec_cnt;
      e.sum_total      = lat_sum;
      expected_q.push_back(e);
    endfunction

    function void compare(string field, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        failures++;
        if (failures <= 10)
          $display("mismatch on %s: expected %0h actual %0h", field, want, got);
      end
    endfunction

    function void check_response(lh_rsp_t a);
      lh_rsp_t e;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10) $display("unexpected response transfer: %h", a);
        return;
      end
      e = expected_q.pop_front();
      compare("bucket_index",   64'(e.bucket_index),   64'(a.bucket_index));
      compare("bucket_value",   64'(e.bucket_value),   64'(a.bucket_value));
      compare("was_overflow",   64'(e.was_overflow),   64'(a.was_overflow));
      compare("min_seen",       64'(e.min_seen),       64'(a.min_seen));
      compare("max_seen",       64'(e.max_seen),       64'(a.max_seen));
      compare("overflow_total", 64'(e.overflow_total), 64'(a.overflow_total));
      compare("sample_total",   64'(e.sample_total),   64'(a.sample_total));
      compare("sum_total",      e.sum_total,           a.sum_total);
    endfunction
  endclass

  logic                      clk;
  logic                      rst        = 1'b1;
  logic                      req_valid  = 1'b0;
  logic                      req_stall;
  lh_req_t                   req        = '0;
  logic                      rsp_valid;
  logic                      rsp_stall  = 1'b0;
  lh_rsp_t                   rsp;
  logic                      cfg_valid  = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index  = '0;
  logic [WIDTH_BITS-1:0]     cfg_data   = '0;

  histogram_scoreboard sb = new();
  bit                  no_idle = 1'b0;
  logic [COUNT_BITS-1:0] cur_count = '0;
  logic [WIDTH_BITS-1:0] cur_width = WIDTH_BITS'(1);

  latency_histogram u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // valid stays high across back-to-back transfers; it is lowered only ahead of a gap or in drain
  task automatic issue_op(input logic [1:0] op, input logic [SAMPLE_BITS-1:0] smp,
                          input logic [INDEX_BITS-1:0] ridx);
    lh_req_t r;
    int      gap;
    r.mode       = op;
    r.sample     = smp;
    r.read_index = ridx;
    gap = no_idle ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    sb.note_request(r);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // count data carries random upper bits, which the block must ignore
  task automatic reconfigure(input logic [COUNT_BITS-1:0] cnt,
                             input logic [WIDTH_BITS-1:0] wid, input bit spare);
    logic [CFG_INDEX_BITS-1:0] idx [3];
    logic [WIDTH_BITS-1:0]     dat [3];
    int                        n;
    drain();
    idx[0] = CFG_BUCKET_COUNT;
    dat[0] = {(WIDTH_BITS - COUNT_BITS)'($urandom), cnt};
    idx[1] = CFG_BUCKET_WIDTH;
    dat[1] = wid;
    idx[2] = CFG_UNMAPPED;
    dat[2] = WIDTH_BITS'($urandom);
    n = spare ? 3 : 2;
    for (int k = 0; k < n; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= dat[k];
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(idx[k], dat[k]);
    end
    cfg_valid <= 1'b0;
    cur_count = cnt;
    cur_width = wid;
  endtask

  function automatic logic [COUNT_BITS-1:0] active_buckets();
    return (cur_count > MAX_BUCKETS_DEF) ? COUNT_BITS'(MAX_BUCKETS_DEF) : cur_count;
  endfunction

  // mostly samples that land inside or just past the active range
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    logic [63:0] span;
    case ($urandom_range(0, 9))
      0: return SAMPLE_BITS'($urandom);
      1: return $urandom_range(0, 1) ? {SAMPLE_BITS{1'b1}} : '0;
      default: begin
        span = 64'(active_buckets()) * 64'(cur_width) + 64'(cur_width);
        if (cur_width == 0) span = 1000;
        if (span > 64'(WIDTH_MAX)) span = 64'(WIDTH_MAX);
        return SAMPLE_BITS'($urandom_range(0, span[31:0]));
      end
    endcase
  endfunction

  function automatic logic [INDEX_BITS-1:0] pick_index();
    int top;
    if ($urandom_range(0, 4) == 0) return INDEX_BITS'($urandom);
    top = int'(active_buckets()) + 4;
    if (top > 1023) top = 1023;
    return INDEX_BITS'($urandom_range(0, top));
  endfunction

  task automatic random_phase(input logic [COUNT_BITS-1:0] cnt,
                              input logic [WIDTH_BITS-1:0] wid);
    int r;
    reconfigure(cnt, wid, 1'($urandom_range(0, 1)));
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (k % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 68)      issue_op(MODE_RECORD, pick_sample(), INDEX_BITS'($urandom));
      else if (r < 90) issue_op(MODE_READ, SAMPLE_BITS'($urandom), pick_index());
      else if (r < 93) issue_op(MODE_CLEAR, SAMPLE_BITS'($urandom), INDEX_BITS'($urandom));
      else if (r < 96) issue_op(MODE_UNUSED, SAMPLE_BITS'($urandom), INDEX_BITS'($urandom));
      else             issue_op(MODE_RECORD, SAMPLE_BITS'($urandom), INDEX_BITS'($urandom));
    end
  endtask

  // response side: random stall after every accepted transfer
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rsp_valid && !rsp_stall) begin
        sb.check_response(rsp);
        hold = no_idle ? 0 : $urandom_range(0, 16);
      end
      rsp_stall <= (hold > 0);
      if (hold > 0) hold--;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset config: no active buckets, every sample overflows
    issue_op(MODE_RECORD, 31'd5, 10'd0);
    issue_op(MODE_READ, 31'd0, 10'd0);
    issue_op(MODE_UNUSED, 31'd0, 10'd0);

    reconfigure(11'd4, 31'd10, 1'b1);
    issue_op(MODE_RECORD, 31'd0, 10'd0);
    issue_op(MODE_RECORD, 31'd39, 10'd0);
    issue_op(MODE_RECORD, 31'd40, 10'd0);
    issue_op(MODE_RECORD, {SAMPLE_BITS{1'b1}}, {INDEX_BITS{1'b1}});
    issue_op(MODE_READ, 31'd0, 10'd0);
    issue_op(MODE_READ, 31'd0, 10'd3);
    issue_op(MODE_READ, 31'd0, 10'd4);
    issue_op(MODE_READ, 31'd0, {INDEX_BITS{1'b1}});
    issue_op(MODE_UNUSED, {SAMPLE_BITS{1'b1}}, {INDEX_BITS{1'b1}});
    issue_op(MODE_CLEAR, 31'd0, 10'd0);
    issue_op(MODE_READ, 31'd0, 10'd0);
    issue_op(MODE_RECORD, 31'd7, 10'd0);

    // count above the store size with a zero divisor
    reconfigure({COUNT_BITS{1'b1}}, '0, 1'b0);
    issue_op(MODE_RECORD, 31'd12, 10'd0);
    issue_op(MODE_READ, 31'd0, {INDEX_BITS{1'b1}});

    reconfigure(11'd1024, 31'd1, 1'b0);
    issue_op(MODE_RECORD, 31'd1023, 10'd0);
    issue_op(MODE_RECORD, 31'd1024, 10'd0);
    issue_op(MODE_READ, 31'd0, 10'd1023);
    issue_op(MODE_CLEAR, 31'd0, 10'd0);

    random_phase(11'd16, 31'd1);
    random_phase(11'd1024, 31'd1);
    random_phase({COUNT_BITS{1'b1}}, 31'd3);
    random_phase(11'd0, WIDTH_BITS'($urandom_range(1, 1000)));
    random_phase(11'd1, WIDTH_MAX);
    random_phase(COUNT_BITS'($urandom_range(1, 1024)), WIDTH_BITS'($urandom_range(1, 1 << 20)));
    random_phase(11'd8, '0);
    random_phase(COUNT_BITS'($urandom_range(1, 64)), WIDTH_BITS'($urandom_range(1, 8)));

    drain();
    repeat (40) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
